>>> src/fba_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package fba_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int ALIGN_DEFAULT = 4;

    localparam int ADDR_W  = 32;
    localparam int IDX_W   = 9;
    localparam int MEM_AW  = $clog2(MAX_BLOCKS);
    localparam int BSIZE_W = 17;
    localparam int SIZE_W  = 18;
    localparam int SPAN_W  = SIZE_W + IDX_W;
    localparam int DIV_W   = 32;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_BLOCKS);

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ALLOC  = 2'd0;
    localparam cmd_t CMD_FREE   = 2'd1;
    localparam cmd_t CMD_REINIT = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_BASE  = 2'd0;
    localparam reg_idx_t REG_SIZE  = 2'd1;
    localparam reg_idx_t REG_COUNT = 2'd2;

    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_address;
        logic [IDX_W-1:0]  free_count;
        logic [IDX_W-1:0]  min_free_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic div_step;
        logic alloc_mul;
        logic alloc_commit;
        logic free_commit;
        logic ri_geom;
        logic ri_span;
        logic ri_walk;
        logic ri_finish;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic walk_last;
    } sts_t;

endpackage

>>> src/fba_datapath.sv
// Datapath of the block pool allocator: configuration and pool registers, the
// link memory, a shared multiplier and a radix-2 restoring divider. Uses fba_pkg.
module fba_datapath #(
    parameter int ALIGN = fba_pkg::ALIGN_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  fba_pkg::reg_idx_t                cfg_index,
    input  logic [fba_pkg::ADDR_W-1:0]       cfg_wdata,
    input  fba_pkg::req_t                    request,
    input  fba_pkg::ctl_t                    ctl,
    output fba_pkg::sts_t                    sts,
    output fba_pkg::rsp_t                    result
);
    import fba_pkg::*;

    // Division by ALIGN is a multiply by a rounded-up reciprocal, exact for any
    // SIZE_W-bit dividend.
    localparam int RND_SH = SIZE_W + $clog2(ALIGN);
    localparam int RND_W  = RND_SH + 1;
    localparam int RND_PW = RND_SH + SIZE_W;
    localparam logic [RND_W-1:0] RND_M = RND_W'((2 ** RND_SH + ALIGN - 1) / ALIGN);

    // Configuration registers, read only by reinit.
    logic [ADDR_W-1:0]  base_cfg_reg;
    logic [BSIZE_W-1:0] bsize_cfg_reg;
    logic [IDX_W-1:0]   bcount_cfg_reg;

    // Latched pool geometry.
    logic [ADDR_W-1:0]  pool_base_reg;
    logic [SIZE_W-1:0]  pool_size_reg;
    logic [IDX_W-1:0]   pool_count_reg;
    logic [SPAN_W-1:0]  span_reg;

    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   free_reg;
    logic [IDX_W-1:0]   min_reg;

    logic [IDX_W-1:0]   link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]   link_q_reg;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [IDX_W-1:0]   mem_wdata;

    logic [DIV_W-1:0]   dividend_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [SIZE_W-1:0]  dsr_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               pre_ok_reg;

    logic [SPAN_W-1:0]  mul_reg;
    logic [IDX_W-1:0]   walk_reg;

    logic               ok_reg;
    logic [ADDR_W-1:0]  baddr_reg;

    logic [SIZE_W:0]    rem_sh;
    logic [SIZE_W:0]    rem_sub;
    logic               rem_ge;
    logic [SIZE_W-1:0]  rem_next;
    logic [SIZE_W-1:0]  size_min;
    logic [SIZE_W-1:0]  size_bumped;
    logic [RND_PW-1:0]  rnd_prod;
    logic [SIZE_W-1:0]  rnd_quo;
    logic [SIZE_W-1:0]  size_round;
    logic [IDX_W-1:0]   count_sat;
    logic [IDX_W-1:0]   mul_a;
    logic [IDX_W-1:0]   free_dec;
    logic [IDX_W-1:0]   walk_inc;
    logic               free_valid;
    logic               head_null;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign rem_ge   = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = rem_ge ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];

    // Rounding up to ALIGN is the quotient of (s + ALIGN - 1) by ALIGN, times ALIGN.
    assign size_min    = (bsize_cfg_reg < BSIZE_W'(ALIGN)) ? SIZE_W'(ALIGN)
                                                           : {1'b0, bsize_cfg_reg};
    assign size_bumped = size_min + SIZE_W'(ALIGN - 1);
    assign rnd_prod    = RND_PW'(size_bumped) * RND_PW'(RND_M);
    assign rnd_quo     = rnd_prod[RND_PW-1:RND_SH];
    assign size_round  = rnd_quo * SIZE_W'(ALIGN);
    assign count_sat   = (bcount_cfg_reg > IDX_W'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS)
                                                               : bcount_cfg_reg;

    assign mul_a     = ctl.ri_span ? pool_count_reg : head_reg;
    assign head_null = (head_reg == NULL_IDX);
    assign free_dec  = (free_reg != '0) ? free_reg - IDX_W'(1) : free_reg;
    assign walk_inc  = walk_reg + IDX_W'(1);

    // The quotient is below the block count whenever the offset is inside the span.
    assign free_valid = pre_ok_reg && (dividend_reg < DIV_W'(span_reg)) && (rem_reg == '0);

    assign sts.div_last  = (dcnt_reg == DCNT_W'(DIV_W - 1));
    assign sts.walk_last = (walk_inc >= pool_count_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_reg[MEM_AW-1:0];
        mem_wdata = (walk_inc < pool_count_reg) ? walk_inc : NULL_IDX;
        if (ctl.ri_walk)
        begin
            mem_we = (walk_reg < pool_count_reg);
        end
        else if (ctl.free_commit)
        begin
            mem_we    = free_valid;
            mem_waddr = quo_reg[MEM_AW-1:0];
            mem_wdata = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        link_q_reg <= link_mem[head_reg[MEM_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg   <= '0;
            bsize_cfg_reg  <= BSIZE_W'(4);
            bcount_cfg_reg <= '0;
            pool_base_reg  <= '0;
            pool_size_reg  <= SIZE_W'(ALIGN);
            pool_count_reg <= '0;
            span_reg       <= '0;
            head_reg       <= NULL_IDX;
            free_reg       <= '0;
            min_reg        <= '0;
            dcnt_reg       <= '0;
            walk_reg       <= '0;
            ok_reg         <= 1'b0;
            baddr_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BASE:  base_cfg_reg   <= cfg_wdata;
                    REG_SIZE:  bsize_cfg_reg  <= cfg_wdata[BSIZE_W-1:0];
                    REG_COUNT: bcount_cfg_reg <= cfg_wdata[IDX_W-1:0];
                    default:   ;
                endcase
            end

            if (ctl.capture)
            begin
                ok_reg    <= 1'b0;
                baddr_reg <= '0;
                dcnt_reg  <= '0;
            end
            else if (ctl.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end

            if (ctl.alloc_commit && !head_null)
            begin
                head_reg  <= link_q_reg;
                free_reg  <= free_dec;
                if (free_dec < min_reg)
                begin
                    min_reg <= free_dec;
                end
                baddr_reg <= pool_base_reg + ADDR_W'(mul_reg);
                ok_reg    <= 1'b1;
            end

            if (ctl.free_commit && free_valid)
            begin
                head_reg <= {1'b0, quo_reg[MEM_AW-1:0]};
                if (free_reg < pool_count_reg)
                begin
                    free_reg <= free_reg + IDX_W'(1);
                end
                ok_reg <= 1'b1;
            end

            if (ctl.ri_geom)
            begin
                pool_base_reg  <= base_cfg_reg;
                pool_size_reg  <= size_round;
                pool_count_reg <= count_sat;
                walk_reg       <= '0;
            end
            else if (ctl.ri_walk)
            begin
                walk_reg <= walk_inc;
            end

            if (ctl.ri_finish)
            begin
                span_reg <= mul_reg;
                head_reg <= (pool_count_reg != '0) ? '0 : NULL_IDX;
                free_reg <= pool_count_reg;
                min_reg  <= pool_count_reg;
                ok_reg   <= 1'b1;
            end
        end
    end

    // Divider and multiplier operands carry no control meaning.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            rem_reg      <= '0;
            pre_ok_reg   <= (request.address != '0) && (request.address >= pool_base_reg);
            dividend_reg <= request.address - pool_base_reg;
            quo_reg      <= request.address - pool_base_reg;
            dsr_reg      <= pool_size_reg;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
        end

        if (ctl.alloc_mul || ctl.ri_span)
        begin
            mul_reg <= SPAN_W'(mul_a) * SPAN_W'(pool_size_reg);
        end
    end

    assign result.ok             = ok_reg;
    assign result.block_address  = baddr_reg;
    assign result.free_count     = free_reg;
    assign result.min_free_count = min_reg;

endmodule

>>> src/fba_controller.sv
// Sequencing state machine of the block pool allocator.
// Drives the datapath commands of fba_pkg::ctl_t and reads fba_pkg::sts_t.
module fba_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fba_pkg::cmd_t  command,
    input  fba_pkg::sts_t  sts,
    output fba_pkg::ctl_t  ctl,
    output logic           busy,
    output logic           done
);
    import fba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_COMMIT,
        S_FREE_DIV,
        S_FREE_PUSH,
        S_RI_GEOM,
        S_RI_SPAN,
        S_RI_WALK,
        S_RI_FINISH,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_ALLOC:  state_next = S_ALLOC_RD;
                        CMD_FREE:   state_next = S_FREE_DIV;
                        CMD_REINIT: state_next = S_RI_GEOM;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_ALLOC_RD:     state_next = S_ALLOC_COMMIT;
            S_ALLOC_COMMIT: state_next = S_RESP;
            S_FREE_DIV:     state_next = sts.div_last ? S_FREE_PUSH : S_FREE_DIV;
            S_FREE_PUSH:    state_next = S_RESP;
            S_RI_GEOM:      state_next = S_RI_SPAN;
            S_RI_SPAN:      state_next = S_RI_WALK;
            S_RI_WALK:      state_next = sts.walk_last ? S_RI_FINISH : S_RI_WALK;
            S_RI_FINISH:    state_next = S_RESP;
            S_RESP:         state_next = S_IDLE;
            default:        state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl              = '0;
        ctl.capture      = start && (state_reg == S_IDLE);
        ctl.div_step     = (state_reg == S_FREE_DIV);
        ctl.alloc_mul    = (state_reg == S_ALLOC_RD);
        ctl.alloc_commit = (state_reg == S_ALLOC_COMMIT);
        ctl.free_commit  = (state_reg == S_FREE_PUSH);
        ctl.ri_geom      = (state_reg == S_RI_GEOM);
        ctl.ri_span      = (state_reg == S_RI_SPAN);
        ctl.ri_walk      = (state_reg == S_RI_WALK);
        ctl.ri_finish    = (state_reg == S_RI_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_next == S_RESP);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

>>> src/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator: a controller and a datapath.
// Depends on fba_pkg, fba_controller and fba_datapath.
//
//  channel   signals                                  transfer when
//  request   start, request (req_t), busy             start high and busy low
//  result    done, result (rsp_t)                     done high, one cycle
//  config    cfg_wr_en, cfg_index, cfg_wdata          cfg_wr_en high
//
// Allocate reads the link memory and multiplies the head index by the block size,
// then commits. Free runs the 32-step serial division of the offset by the block
// size, then pushes the block. Reinit latches the rounded size and the block count,
// forms the span, then writes the link memory one entry a cycle. A command with no
// meaning goes straight to the response.
// Reset leaves an empty pool. The receiver cannot stall; each result is shown
// for exactly one cycle.
module fixed_block_pool_allocator #(
    parameter int ALIGN = fba_pkg::ALIGN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  fba_pkg::reg_idx_t           cfg_index,
    input  logic [fba_pkg::ADDR_W-1:0]  cfg_wdata,
    input  logic                        start,
    input  fba_pkg::req_t               request,
    output logic                        busy,
    output logic                        done,
    output fba_pkg::rsp_t               result
);
    import fba_pkg::*;

    ctl_t ctl;
    sts_t sts;

    fba_controller u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    fba_datapath #(
        .ALIGN (ALIGN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .ctl       (ctl),
        .sts       (sts),
        .result    (result)
    );

endmodule
